// ----- rtl/wgini_pkg.sv -----
// wgini_pkg: shared widths, status codes and control/status types for the
// weighted gini index block. depends on nothing; used by every rtl file.
package wgini_pkg;

  localparam int WEIGHT_W = 12;
  localparam int INCOME_W = 20;
  localparam int CUM_W_W  = 22;  // cumulative weight
  localparam int CUM_V_W  = 42;  // cumulative weighted income
  localparam int ACC_W    = 64;  // area accumulator
  localparam int GINI_W   = 17;
  localparam int STATUS_W = 2;

  localparam int DEF_MAX_ITEMS        = 1024;
  localparam int DEF_RESULT_FRAC_BITS = 16;

  localparam logic [GINI_W-1:0] GINI_MAX = {GINI_W{1'b1}};

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_TOTAL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_ASCEND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY   = 2'd3;

  // controller to datapath commands, at most one high per cycle
  typedef struct packed {
    logic load;
    logic diff;
    logic mulw;
    logic accum;
    logic den;
    logic prep;
    logic div_step;
    logic emit;
  } wgini_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last;
    logic direct;
    logic out_free;
  } wgini_stat_t;

endpackage

// ----- rtl/wgini_ctrl.sv -----
// wgini_ctrl: state machine sequencing one record and the final division.
// depends on wgini_pkg.
module wgini_ctrl
  import wgini_pkg::*;
#(
  parameter int RESULT_FRAC_BITS = DEF_RESULT_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  wgini_stat_t stat,
  output wgini_cmd_t  cmd
);

  localparam int SW = $clog2(RESULT_FRAC_BITS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIFF  = 3'd1;
  localparam logic [2:0] S_MULW  = 3'd2;
  localparam logic [2:0] S_ACCUM = 3'd3;
  localparam logic [2:0] S_DEN   = 3'd4;
  localparam logic [2:0] S_PREP  = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [SW-1:0] step;
  logic [SW-1:0] step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_MULW;
      end
      S_MULW: begin
        cmd.mulw   = 1'b1;
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = stat.last ? S_DEN : S_IDLE;
      end
      S_DEN: begin
        cmd.den    = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        step_next  = SW'(RESULT_FRAC_BITS);
        state_next = stat.direct ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step - SW'(1);
        if (step == SW'(1)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

// ----- rtl/wgini_dp.sv -----
// wgini_dp: accumulators, multipliers, restoring divider and result register.
// depends on wgini_pkg; driven by wgini_ctrl commands.
module wgini_dp
  import wgini_pkg::*;
#(
  parameter int MAX_ITEMS        = DEF_MAX_ITEMS,
  parameter int RESULT_FRAC_BITS = DEF_RESULT_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  wgini_cmd_t          cmd,
  output wgini_stat_t         stat,
  input  logic [WEIGHT_W-1:0] weight,
  input  logic [INCOME_W-1:0] income,
  input  logic                last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [GINI_W-1:0]   gini_q16,
  output logic [STATUS_W-1:0] status
);

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int QW = RESULT_FRAC_BITS + 1;
  localparam int GW = (QW > GINI_W) ? QW : GINI_W;

  // per-set state
  logic [CUM_W_W-1:0]  cum_weight;
  logic [CUM_V_W-1:0]  cum_weighted_income;
  logic [ACC_W-1:0]    area_accum;
  logic [CW-1:0]       item_count;
  logic [STATUS_W-1:0] error_flags;
  logic [INCOME_W-1:0] prev_income;

  // record pipeline registers
  logic [WEIGHT_W-1:0]          w_r;
  logic                         last_r;
  logic                         take_r;
  logic [CUM_V_W-1:0]           prod_yw;
  logic [WEIGHT_W+INCOME_W-1:0] prod_wy;
  logic [CUM_V_W-1:0]           diff;
  logic [WEIGHT_W+CUM_V_W-1:0]  prod_wd;

  // division
  logic [ACC_W-1:0]    den;
  logic [ACC_W-1:0]    rem;
  logic [QW-1:0]       quo;
  logic [STATUS_W-1:0] res_status;
  logic [ACC_W:0]      rem_shl;
  logic                sub_ok;
  logic                zero_total;
  logic                acc_ge;
  logic [GW-1:0]       quo_ext;

  assign zero_total = (cum_weight == '0) || (cum_weighted_income == '0);
  assign acc_ge     = (area_accum >= den);
  assign rem_shl    = {rem, 1'b0};
  assign sub_ok     = (rem_shl >= {1'b0, den});
  assign quo_ext    = GW'(quo);

  assign stat.last     = last_r;
  assign stat.direct   = (error_flags != ST_OK) || zero_total || acc_ge;
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r     <= weight;
      last_r  <= last;
      prod_yw <= CUM_V_W'(income) * CUM_V_W'(cum_weight);
      prod_wy <= weight * income;
    end
    if (cmd.diff) begin
      diff <= prod_yw - cum_weighted_income;
    end
    if (cmd.mulw) begin
      prod_wd <= w_r * diff;
    end
    if (cmd.den) begin
      den <= ACC_W'(cum_weight) * ACC_W'(cum_weighted_income);
    end
    if (cmd.prep) begin
      rem <= area_accum;
      if (error_flags != ST_OK) begin
        res_status <= error_flags;
        quo        <= '0;
      end else if (zero_total) begin
        res_status <= ST_ZERO_TOTAL;
        quo        <= '0;
      end else if (acc_ge) begin
        res_status <= ST_OK;
        quo        <= QW'(1) << RESULT_FRAC_BITS;
      end else begin
        res_status <= ST_OK;
        quo        <= '0;
      end
    end
    if (cmd.div_step) begin
      quo <= {quo[QW-2:0], sub_ok};
      rem <= sub_ok ? ACC_W'(rem_shl - {1'b0, den}) : rem_shl[ACC_W-1:0];
    end
    if (cmd.emit) begin
      status   <= res_status;
      // clamp to the field maximum when many fraction bits are in use
      gini_q16 <= (quo_ext > GW'(GINI_MAX)) ? GINI_MAX : quo_ext[GINI_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cum_weight          <= '0;
      cum_weighted_income <= '0;
      area_accum          <= '0;
      item_count          <= '0;
      error_flags         <= ST_OK;
      prev_income         <= '0;
      take_r              <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        prev_income <= income;
        if (error_flags == ST_OK) begin
          if (item_count >= CW'(MAX_ITEMS)) begin
            error_flags <= ST_TOO_MANY;
            take_r      <= 1'b0;
          end else if ((item_count != '0) && (income < prev_income)) begin
            error_flags <= ST_NOT_ASCEND;
            take_r      <= 1'b0;
          end else begin
            take_r <= 1'b1;
          end
        end else begin
          take_r <= 1'b0;
        end
      end
      if (cmd.accum && take_r) begin
        area_accum          <= area_accum + ACC_W'(prod_wd);
        cum_weight          <= cum_weight + CUM_W_W'(w_r);
        cum_weighted_income <= cum_weighted_income + CUM_V_W'(prod_wy);
        item_count          <= item_count + CW'(1);
      end
      if (cmd.emit) begin
        cum_weight          <= '0;
        cum_weighted_income <= '0;
        area_accum          <= '0;
        item_count          <= '0;
        error_flags         <= ST_OK;
      end
    end
  end

endmodule

// ----- rtl/weighted_gini_index.sv -----
// weighted_gini_index: a record passes through load, difference, weight
// multiply and accumulate, and no new request is taken until it is through.
// a last record adds the denominator multiply and compare, then the
// one-bit-per-cycle restoring divider, skipped for error, zero-total and
// saturated sets, and then the result load, which waits for a free output.
// synchronous active-high reset clears all per-set state and the output.
module weighted_gini_index
  import wgini_pkg::*;
#(
  parameter int MAX_ITEMS        = DEF_MAX_ITEMS,
  parameter int RESULT_FRAC_BITS = DEF_RESULT_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // input records
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // weight [11:0], income [31:12]
  input  logic        s_tlast,   // last record of the data set
  // results, one per data set
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // gini_q16 [16:0], zero fill [23:17]
  output logic [1:0]  m_tuser    // status [1:0]
);

  wgini_cmd_t          cmd;
  wgini_stat_t         stat;
  logic [GINI_W-1:0]   gini_q16;

  // sequencer: one record at a time, then the division on the last one
  wgini_ctrl #(
    .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // accumulators, divider and the output register
  wgini_dp #(
    .MAX_ITEMS        (MAX_ITEMS),
    .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .weight    (s_tdata[WEIGHT_W-1:0]),
    .income    (s_tdata[WEIGHT_W+INCOME_W-1:WEIGHT_W]),
    .last      (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .gini_q16  (gini_q16),
    .status    (m_tuser)
  );

  // result padded to whole bytes
  assign m_tdata = {7'd0, gini_q16};

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench for weighted_gini_index. streams weighted
// income records in sets and checks every per-set gini result and status
// against a predictor kept here. depends on wgini_pkg and the block's rtl.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wgini_pkg::*;

  localparam int SET_LIMIT    = DEF_MAX_ITEMS;
  localparam int FRAC_BITS    = DEF_RESULT_FRAC_BITS;
  localparam int INCOME_MAX   = (1 << INCOME_W) - 1;
  localparam int RANDOM_ITEMS = 900;
  localparam int QUIET_ITEMS  = 150;   // tail of the random part, no idling
  localparam int LONG_HOLD    = 300;   // long result back-pressure stretch
  localparam int STALL_LIMIT  = 2000;  // cycles with nothing taken on either side
  localparam int DRAIN_CYCLES = 40;    // covers the divider and result load

  localparam logic [WEIGHT_W-1:0] W_TOP = '1;
  localparam logic [INCOME_W-1:0] Y_TOP = '1;

  typedef struct packed {
    logic [GINI_W-1:0]   gini;
    logic [STATUS_W-1:0] status;
  } gini_result_t;

  typedef enum {SET_ASCENDING, SET_SHUFFLED, SET_ZERO_WEIGHT, SET_ZERO_INCOME} set_kind_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // weight [11:0], income [31:12]
  logic        s_tlast;   // last record of the data set
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // gini_q16 [16:0], zero fill [23:17]
  logic [1:0]  m_tuser;   // status [1:0]

  // predictor state, mirrors the per-set accumulators of the block
  logic [CUM_W_W-1:0]  run_weight;
  logic [CUM_V_W-1:0]  run_wincome;
  logic [ACC_W-1:0]    area_sum;
  logic [INCOME_W-1:0] prev_income;
  int                  set_count;
  logic [STATUS_W-1:0] set_status;
  gini_result_t        gini_expected[$];

  int   records_taken     = 0;
  int   mismatch_count    = 0;
  int   quiet_cycles      = 0;
  logic idling_on         = 1'b1;
  logic sink_hold_pending = 1'b0;

  weighted_gini_index #(
    .MAX_ITEMS        (SET_LIMIT),
    .RESULT_FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  task automatic clear_set_state();
    run_weight  = '0;
    run_wincome = '0;
    area_sum    = '0;
    set_count   = 0;
    set_status  = ST_OK;
  endtask

  // folds one accepted request into the running area sum; on a last record
  // it queues the gini fraction (or the latched error) for the set
  task automatic gini_fold_record(input logic [WEIGHT_W-1:0] w,
                                  input logic [INCOME_W-1:0] y,
                                  input logic is_last);
    logic [63:0]  gap;
    logic [63:0]  den;
    logic [127:0] quot;
    gini_result_t res;
    // first error wins: once latched, the rest of the set is not accumulated
    if (set_status == ST_OK) begin
      if (set_count >= SET_LIMIT) begin
        set_status = ST_TOO_MANY;
      end else if (set_count != 0 && y < prev_income) begin
        set_status = ST_NOT_ASCEND;
      end else begin
        // area term w*(y*W - V), all of it modulo 2^64
        gap         = 64'(y) * 64'(run_weight) - 64'(run_wincome);
        area_sum    = area_sum + 64'(w) * gap;
        run_weight  = run_weight + CUM_W_W'(w);
        run_wincome = run_wincome + CUM_V_W'(64'(w) * 64'(y));
        set_count   = set_count + 1;
      end
    end
    prev_income = y;
    if (is_last) begin
      res.gini   = '0;
      res.status = set_status;
      if (set_status == ST_OK) begin
        if (run_weight == '0 || run_wincome == '0) begin
          res.status = ST_ZERO_TOTAL;
        end else begin
          // truncated area/(W*V) with FRAC_BITS fraction bits, saturated at one
          den = 64'(run_weight) * 64'(run_wincome);
          if (area_sum >= den) quot = 128'(1) << FRAC_BITS;
          else quot = (128'(area_sum) << FRAC_BITS) / 128'(den);
          if (quot > (128'(1) << FRAC_BITS)) quot = 128'(1) << FRAC_BITS;
          if (quot > 128'(GINI_MAX)) quot = 128'(GINI_MAX);
          res.gini = quot[GINI_W-1:0];
        end
      end
      gini_expected.push_back(res);
      clear_set_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offers one record and holds it until the block takes it; valid stays high
  // afterwards so back-to-back records are offered without dropping valid
  task automatic send_record(input logic [WEIGHT_W-1:0] w,
                             input logic [INCOME_W-1:0] y,
                             input logic is_last);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {y, w};
    s_tlast  <= is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    records_taken++;
    gini_fold_record(w, y, is_last);
  endtask

  // valid low for a gap whose length is given by n, with junk on the data lines that must be ignored
  task automatic sender_gap(input int n);
    @(negedge clk);
    s_tvalid <= 1'b0;
    s_tdata  <= $urandom;
    s_tlast  <= 1'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic random_pause();
    if (idling_on && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 15));
  endtask

  // drop valid and hold off until every queued result has come back
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (gini_expected.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return W_TOP;
      2:       return WEIGHT_W'($urandom_range(0, 15));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  // one data set of n records; ascending sets take random steps of very
  // different sizes so both small and near-full-scale incomes show up
  task automatic send_random_set(input int n, input set_kind_t kind);
    int                  y;
    int                  i;
    logic [WEIGHT_W-1:0] w;
    y = $urandom_range(0, INCOME_MAX) >> $urandom_range(0, INCOME_W);
    for (i = 0; i < n; i++) begin
      case (kind)
        SET_SHUFFLED:    y = $urandom_range(0, INCOME_MAX);
        SET_ZERO_INCOME: y = 0;
        default: begin
          if (i != 0) y = y + $urandom_range(0, 1 << $urandom_range(0, 16));
          if (y > INCOME_MAX) y = INCOME_MAX;
        end
      endcase
      w = (kind == SET_ZERO_WEIGHT) ? '0 : pick_weight();
      random_pause();
      send_record(w, y[INCOME_W-1:0], i == n - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, plus one long hold on request
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_pending) begin
        sink_hold_pending = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // each taken result against the oldest expectation
  always @(posedge clk) begin : result_check
    gini_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (gini_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: gini %0d status %0d",
                   m_tdata[GINI_W-1:0], m_tuser);
      end else begin
        want = gini_expected.pop_front();
        if (m_tdata[GINI_W-1:0] !== want.gini || m_tuser !== want.status ||
            m_tdata[23:GINI_W] !== '0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected gini %0d status %0d, got gini %0d status %0d fill %0h",
                     want.gini, want.status, m_tdata[GINI_W-1:0], m_tuser,
                     m_tdata[23:GINI_W]);
        end
      end
    end
  end

  // watchdog on cycles where neither side moves anything
  always @(posedge clk) begin : stall_watch
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // full-scale fields, zero totals, exact and truncated fractions
  task automatic test_field_extremes();
    send_record(W_TOP, Y_TOP, 1'b1);              // lone record, zero area
    send_record('0, Y_TOP, 1'b1);                 // zero total weight
    send_record(12'd5, '0, 1'b0);                 // zero total income
    send_record(12'd7, '0, 1'b1);
    send_record(W_TOP, '0, 1'b0);                 // exactly one half
    send_record(W_TOP, Y_TOP, 1'b1);
    send_record(W_TOP, '0, 1'b0);                 // close to one
    send_record(12'd1, Y_TOP, 1'b1);
    send_record(12'h555, 20'h55555, 1'b0);        // alternating bit patterns
    send_record(12'haaa, 20'haaaaa, 1'b1);
    send_record(12'd1, 20'd1, 1'b0);              // 2/15, truncated
    send_record(12'd2, 20'd2, 1'b1);
    wait_drained();
  endtask

  // descending income mid set and on the last record; equal incomes and a
  // set opening below the previous set's last income are both fine
  task automatic test_error_codes();
    send_record(12'd10, 20'd500, 1'b0);
    send_record(12'd10, 20'd400, 1'b0);
    send_record(12'd10, 20'd600, 1'b1);
    send_record(12'd3, 20'd100, 1'b0);
    send_record(12'd3, 20'd100, 1'b1);
    send_record(12'd9, 20'd800, 1'b0);
    send_record(12'd9, 20'd700, 1'b1);
    send_record(12'd4, 20'd50, 1'b1);
    wait_drained();
  endtask

  // a set at the record limit with full-scale sums, then one past it whose
  // later descending record must not replace the too-many code
  task automatic test_set_length();
    int i;
    idling_on = 1'b0;
    for (i = 0; i < SET_LIMIT; i++)
      send_record(W_TOP, (i < SET_LIMIT / 2) ? '0 : Y_TOP, i == SET_LIMIT - 1);
    for (i = 0; i <= SET_LIMIT; i++)
      send_record(pick_weight(), INCOME_W'(i), 1'b0);
    send_record(12'd1, '0, 1'b1);
    wait_drained();
    idling_on = 1'b1;
  endtask

  // results held back long enough that the block's output fills and it stops
  // taking records; afterwards the sender waits for everything to drain
  task automatic test_backpressure();
    idling_on = 1'b0;
    sink_hold_pending = 1'b1;
    repeat (6) send_random_set(2, SET_ASCENDING);
    wait_drained();
    idling_on = 1'b1;
  endtask

  // mostly well-formed ascending sets, some shuffled, zero-weight and
  // zero-income sets; idling switched off for the tail
  task automatic test_random_sets();
    int        first;
    int        n;
    int        r;
    set_kind_t kind;
    first = records_taken;
    idling_on = 1'b1;
    while (records_taken - first < RANDOM_ITEMS) begin
      if (records_taken - first >= RANDOM_ITEMS - QUIET_ITEMS) idling_on = 1'b0;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      r = $urandom_range(0, 19);
      if (r < 16) kind = SET_ASCENDING;
      else if (r < 18) kind = SET_SHUFFLED;
      else if (r == 18) kind = SET_ZERO_WEIGHT;
      else kind = SET_ZERO_INCOME;
      send_random_set(n, kind);
    end
  endtask

  initial begin : stimulus
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    clear_set_state();
    prev_income = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_error_codes();
    test_set_length();
    test_backpressure();
    test_random_sets();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (gini_expected.size() != 0) mismatch_count++;
    if (mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
